// File: rtl/pcp_pkg.sv
// shared types, codes and helpers for the pubsub command line parser
// no dependencies; imported by every module of the block
package pcp_pkg;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_SP = 8'h20;

    localparam logic [1:0] KIND_DATA     = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    localparam logic [1:0] PHASE_CMD     = 2'd0;
    localparam logic [1:0] PHASE_TOPIC   = 2'd1;
    localparam logic [1:0] PHASE_CONTENT = 2'd2;

    localparam logic [2:0] MATCH_FULL = 3'd3;
    localparam logic [2:0] MATCH_FAIL = 3'd4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] field;
        logic [7:0] out_byte;
        logic       is_pub;
        logic       last;
    } result_t;

    // results produced by one accepted byte, first result in r0
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    // letter of "pub" expected at a given match position
    function automatic logic [7:0] pub_letter(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0:    c = 8'h70;
            2'd1:    c = 8'h75;
            default: c = 8'h62;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] match_step(input logic [2:0] m, input logic [7:0] b);
        logic [2:0] nm;
        if (m < MATCH_FULL && b == pub_letter(m[1:0]))
            nm = m + 3'd1;
        else
            nm = MATCH_FAIL;
        return nm;
    endfunction

endpackage

// File: rtl/pubsub_command_line_parser_unit.sv
// pubsub command line parser: byte stream in, tagged field bytes and message events out
// Channels: s_axis carries one raw byte per transaction in s_axis_tdata[7:0].
// m_axis carries one result per transaction: tdata holds the data byte, tuser
// holds kind, field and the pub flag, tlast marks the last result of one input.
// A byte causes zero, one or two results (a held CR resolved by a byte that is data
// itself gives the CR and then the new byte).
// Results are queued when their byte is taken and offered on m_axis in order.
// Throughput: one byte per cycle while the receiver keeps up; the four-entry
// result queue sets the figure, s_axis_tready is high while two entries are free.
// When the receiver stalls, results wait in the queue and input stops once
// fewer than two entries remain.
// Reset clears the parser to the start of a message (command field, no CR held,
// no command letters matched) and empties the queue.
// After a completion or an error the next byte starts a new message.
// depends on pcp_pkg, pcp_parser, pcp_outq
module pubsub_command_line_parser_unit
    import pcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [4:0] m_axis_tuser,   // [1:0] kind, [3:2] field, [4] is_pub
    output logic       m_axis_tlast
);

    push_t   push;
    result_t head;
    logic    room;
    logic    accept;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    pcp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_axis_tdata),
        .push    (push)
    );

    pcp_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (m_axis_tready),
        .room       (room),
        .head_valid (m_axis_tvalid),
        .head       (head)
    );

    assign m_axis_tdata = head.out_byte;
    assign m_axis_tuser = {head.is_pub, head.field, head.kind};
    assign m_axis_tlast = head.last;

endmodule

// File: rtl/pcp_parser.sv
// parser state and per-byte decode: turns one accepted byte into zero to two results
// depends on pcp_pkg
module pcp_parser
    import pcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output push_t      push
);

    logic [1:0] phase_reg, phase_next;
    logic       cr_reg, cr_next;
    logic [2:0] match_reg, match_next;

    always_comb
    begin
        result_t    res [2];
        logic [1:0] n;
        logic       done;
        logic [1:0] ph;
        logic       cr;
        logic [2:0] mt;

        res[0] = '0;
        res[1] = '0;
        n      = 2'd0;
        done   = 1'b0;
        ph     = phase_reg;
        cr     = cr_reg;
        mt     = match_reg;

        if (cr)
        begin
            cr = 1'b0;
            if (in_byte == BYTE_LF)
            begin
                done = 1'b1;
                if (ph == PHASE_CMD)
                begin
                    res[0].kind = KIND_ERROR;
                    n  = 2'd1;
                    ph = PHASE_CMD;
                    mt = '0;
                end
                else if (ph == PHASE_TOPIC && mt == MATCH_FULL)
                begin
                    ph = PHASE_CONTENT;
                end
                else
                begin
                    res[0].kind   = KIND_COMPLETE;
                    res[0].is_pub = (ph != PHASE_TOPIC);
                    n  = 2'd1;
                    ph = PHASE_CMD;
                    mt = '0;
                end
            end
            else
            begin
                // lone cr becomes data of the current field
                res[0].kind     = KIND_DATA;
                res[0].field    = ph;
                res[0].out_byte = BYTE_CR;
                if (ph == PHASE_CMD)
                    mt = match_step(mt, BYTE_CR);
                n = 2'd1;
            end
        end

        if (!done)
        begin
            if (in_byte == BYTE_CR)
                cr = 1'b1;
            else if (ph == PHASE_CMD && in_byte == BYTE_SP)
                ph = PHASE_TOPIC;
            else
            begin
                res[n[0]].kind     = KIND_DATA;
                res[n[0]].field    = ph;
                res[n[0]].out_byte = in_byte;
                if (ph == PHASE_CMD)
                    mt = match_step(mt, in_byte);
                n = n + 2'd1;
            end
        end

        if (n == 2'd1)
            res[0].last = 1'b1;
        else if (n == 2'd2)
            res[1].last = 1'b1;

        push.count = accept ? n : 2'd0;
        push.r0    = res[0];
        push.r1    = res[1];
        phase_next = ph;
        cr_next    = cr;
        match_next = mt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_CMD;
            cr_reg    <= 1'b0;
            match_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cr_reg    <= cr_next;
            match_reg <= match_next;
        end
    end

endmodule

// File: rtl/pcp_outq.sv
// result queue: takes up to two results a cycle, hands one a cycle to the output while pop is high
// depends on pcp_pkg
module pcp_outq
    import pcp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output logic    room,
    output logic    head_valid,
    output result_t head
);

    result_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_pop;

    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;
    // space for the worst case of two results from one byte
    assign room       = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb
    begin
        cnt_next = cnt_reg + QCNT_W'(push.count) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_reg + QPTR_W'(1)] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push.count);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/pcp_checker.sv
// port-level checks for the pubsub command line parser
// depends on pcp_pkg; bound to pubsub_command_line_parser_unit
module pcp_checker
    import pcp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [4:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
        else $error("undefined result kind");

    // completion and error are always the last result of their byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] != KIND_DATA |-> m_axis_tlast)
        else $error("event result without tlast");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] != KIND_DATA
        |-> m_axis_tdata == 8'd0 && m_axis_tuser[3:2] == 2'd0)
        else $error("event result carries data");

    // the pub flag only appears on completion results
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[4] |-> m_axis_tuser[1:0] == KIND_COMPLETE)
        else $error("pub flag on non-completion result");

endmodule

bind pubsub_command_line_parser_unit pcp_checker u_pcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb.sv
// testbench for pubsub_command_line_parser_unit: byte stream in, tagged results checked
// against an in-bench parser model with random stalls on both stream sides
// depends on pcp_pkg and the rtl of the block
module tb;
    import pcp_pkg::*;

    localparam logic [7:0] PUB_WORD [3] = '{8'h70, 8'h75, 8'h62};
    localparam int PHASE_BYTES  = 140;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT  = 20000;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] in_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [7:0] out_byte
    logic [4:0] m_axis_tuser;    // [1:0] kind, [3:2] field, [4] is_pub
    logic       m_axis_tlast;

    // parser model state
    logic [1:0] msg_phase;
    logic       cr_held;
    logic [2:0] cmd_match;
    result_t    parsed_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int bytes_sent;
    int error_count;

    pubsub_command_line_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic void start_message();
        msg_phase = PHASE_CMD;
        cr_held   = 1'b0;
        cmd_match = 3'd0;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [1:0] fld,
                                        logic [7:0] data, logic pub);
        result_t r;
        r.kind     = kind;
        r.field    = fld;
        r.out_byte = data;
        r.is_pub   = pub;
        r.last     = 1'b0;
        parsed_q.push_back(r);
    endfunction

    // field code equals the phase code, so the phase tags the byte directly
    function automatic void push_data(logic [7:0] data);
        if (msg_phase == PHASE_CMD)
        begin
            if (cmd_match < MATCH_FULL && data == PUB_WORD[cmd_match[1:0]])
                cmd_match = cmd_match + 3'd1;
            else
                cmd_match = MATCH_FAIL;
        end
        push_result(KIND_DATA, msg_phase, data, 1'b0);
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        int n_out;
        n_out = 0;
        if (cr_held && b == BYTE_LF)
        begin
            cr_held = 1'b0;
            if (msg_phase == PHASE_CMD)
            begin
                push_result(KIND_ERROR, 2'd0, 8'd0, 1'b0);
                start_message();
                n_out = 1;
            end
            else if (msg_phase == PHASE_TOPIC && cmd_match == MATCH_FULL)
                msg_phase = PHASE_CONTENT;
            else
            begin
                push_result(KIND_COMPLETE, 2'd0, 8'd0, msg_phase == PHASE_CONTENT);
                start_message();
                n_out = 1;
            end
        end
        else
        begin
            // a held cr not followed by lf is plain data
            if (cr_held)
            begin
                push_data(BYTE_CR);
                n_out++;
            end
            cr_held = (b == BYTE_CR);
            if (b == BYTE_CR)
                ;
            else if (msg_phase == PHASE_CMD && b == BYTE_SP)
                msg_phase = PHASE_TOPIC;
            else
            begin
                push_data(b);
                n_out++;
            end
        end
        if (n_out > 0)
            parsed_q[parsed_q.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (parsed_q.size() == 0)
            begin
                $error("unexpected result: tuser 0x%0h tdata 0x%0h tlast %0b",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = parsed_q.pop_front();
                compare_field("kind", want.kind, m_axis_tuser[1:0]);
                compare_field("field", want.field, m_axis_tuser[3:2]);
                compare_field("out_byte", want.out_byte, m_axis_tdata);
                compare_field("is_pub", want.is_pub, m_axis_tuser[4]);
                compare_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // receiver side stalls
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------- stimulus

    // entered and left at a falling edge
    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        parse_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_crlf();
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
    endtask

    // hold the sender until every pending result has been taken
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (parsed_q.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        if (parsed_q.size() != 0)
        begin
            $error("%0d results never arrived", parsed_q.size());
            error_count++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] rand_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 8'($urandom_range(8'h21, 8'h7E));
        else if (r < 85)
            return BYTE_SP;
        else if (r < 92)
            return BYTE_CR;
        else if (r < 96)
            return BYTE_LF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_cmd_byte();
        logic [7:0] b;
        if ($urandom_range(0, 9) != 0)
            return 8'($urandom_range(8'h21, 8'h7E));
        b = 8'($urandom_range(0, 255));
        return (b == BYTE_SP) ? 8'h7E : b;
    endfunction

    task automatic send_message();
        logic [7:0] msg[$];
        int         sel;
        int         len;
        logic       pub_cmd;
        sel     = $urandom_range(0, 99);
        pub_cmd = 1'b0;
        if (sel < 5)
        begin
            // raw noise
            len = $urandom_range(1, 6);
            repeat (len) msg.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if (sel < 50)
            begin
                foreach (PUB_WORD[i]) msg.push_back(PUB_WORD[i]);
                pub_cmd = 1'b1;
            end
            else if (sel < 65)
            begin
                // partial or overrun match of the pub word
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) msg.push_back(PUB_WORD[i]);
                if (len < 3 || $urandom_range(0, 1))
                    msg.push_back(rand_cmd_byte());
            end
            else
            begin
                len = $urandom_range(1, 5);
                repeat (len) msg.push_back(rand_cmd_byte());
            end
            if ($urandom_range(0, 99) >= 10)
            begin
                msg.push_back(BYTE_SP);
                len = $urandom_range(0, 6);
                repeat (len) msg.push_back(rand_text_byte());
                msg.push_back(BYTE_CR);
                msg.push_back(BYTE_LF);
                if (pub_cmd)
                begin
                    len = $urandom_range(0, 8);
                    repeat (len) msg.push_back(rand_text_byte());
                end
            end
            msg.push_back(BYTE_CR);
            msg.push_back(BYTE_LF);
        end
        foreach (msg[i]) send_byte(msg[i]);
    endtask

    task automatic send_random_messages(int n_bytes);
        int start_count;
        start_count = bytes_sent;
        while (bytes_sent - start_count < n_bytes)
            send_message();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        // missing space gives an error
        send_crlf();
        // pub message; content holds extreme bytes, a space, lone lf and a lone cr sent just ahead of the closing crlf
        send_text("pub a");
        send_crlf();
        send_byte(8'h00);
        send_byte(BYTE_SP);
        send_byte(8'hFF);
        send_byte(BYTE_LF);
        send_byte(BYTE_CR);
        send_crlf();
        // partial match, second space is topic data
        send_text("pu  ");
        send_crlf();
        // lone cr resolved by the command space
        send_text("p");
        send_byte(BYTE_CR);
        send_text(" ");
        send_crlf();
        wait_drained();
    endtask

    task automatic test_slow_receiver();
        send_idle_pct = 35;
        recv_idle_pct = 85;
        send_random_messages(PHASE_BYTES);
        wait_drained();
    endtask

    task automatic test_slow_sender();
        send_idle_pct = 85;
        recv_idle_pct = 35;
        send_random_messages(PHASE_BYTES);
        wait_drained();
    endtask

    task automatic test_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_messages(PHASE_BYTES);
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        send_idle_pct = 35;
        recv_idle_pct = 85;
        bytes_sent    = 0;
        error_count   = 0;
        start_message();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_slow_receiver();
        test_slow_sender();
        test_full_rate();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
